// ----- rtl/skct_pkg.sv -----
// ----------------------------------------------------------------------------
// skct_pkg
// Shared types and constants for the sorted key / child table.
// ----------------------------------------------------------------------------
package skct_pkg;

  // default geometry
  localparam int SLOTS_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 32;

  // fixed field widths
  localparam int KEY_W    = 8;
  localparam int CHILD_W  = 32;
  localparam int CAP_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int CAP_RST  = 16;

  // operation codes; the spare code behaves as a lookup
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // update request broadcast to every cell
  typedef struct packed {
    logic              do_ins;
    logic              do_rem;
    logic [KEY_W-1:0]  key;
  } op_t;

endpackage

// ----- rtl/skct_cell.sv -----
// ----------------------------------------------------------------------------
// skct_cell
// One table slot: holds a key, its handle and a valid bit, compares against
// the request key and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module skct_cell
  import skct_pkg::*;
#(
  parameter int HANDLE_W = HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  op_t                 op,
  input  logic [HANDLE_W-1:0] new_handle,
  // lower neighbor
  input  logic                prev_lt,
  input  logic                prev_valid,
  input  logic [KEY_W-1:0]    prev_key,
  input  logic [HANDLE_W-1:0] prev_handle,
  // upper neighbor
  input  logic                next_valid,
  input  logic [KEY_W-1:0]    next_key,
  input  logic [HANDLE_W-1:0] next_handle,
  // state and compare results
  output logic                lt,
  output logic                eq,
  output logic                at,
  output logic                valid,
  output logic [KEY_W-1:0]    key,
  output logic [HANDLE_W-1:0] handle
);

  // compare; keys stay sorted so lt is a thermometer across the row
  assign lt = valid && (key < op.key);
  assign eq = valid && (key == op.key);
  // first slot whose key is not below the request key
  assign at = !lt && prev_lt;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.do_ins && at) begin
      valid <= 1'b1;
    end else if (op.do_ins && !lt) begin
      valid <= prev_valid;
    end else if (op.do_rem && !lt) begin
      valid <= next_valid;
    end
  end

  // payload: new entry, shift up from below, or shift down from above
  always_ff @(posedge clk) begin
    if (op.do_ins && at) begin
      key    <= op.key;
      handle <= new_handle;
    end else if (op.do_ins && !lt) begin
      key    <= prev_key;
      handle <= prev_handle;
    end else if (op.do_rem && !lt) begin
      key    <= next_key;
      handle <= next_handle;
    end
  end

endmodule

// ----- rtl/sorted_key_child_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_key_child_table_top
// Sorted key byte / child handle table, node16 style, built as a row of cells.
// ----------------------------------------------------------------------------
// The table keeps up to SLOTS key bytes in ascending order with a child handle
// each. One request (lookup, insert, remove) is taken per clock: every cell
// compares its key against the request key in parallel, and on insert or
// remove each cell loads from its lower or upper neighbor in that same cycle;
// the result appears on the master side in the cycle after acceptance. The
// next request is accepted in the cycle the previous result is taken, so the
// block sustains one request per cycle while m_tready stays high; a result
// that waits holds s_tready low. The user must write the capacity through
// cfg_we/cfg_data only while the block is idle; the block does not enforce
// it. Values above SLOTS act as SLOTS and zero makes every insert report full.
// An insert into a full table returns status full and leaves the table as is.
module sorted_key_child_table_top
  import skct_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: capacity
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_data,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // key_byte[7:0], child_handle[39:8]
  input  logic [1:0]        s_tuser,   // command[1:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // found_handle[31:0], slot_index[35:32],
                                       // entry_count[40:36], zero fill above
  output logic [1:0]        m_tuser    // status[1:0]
);

  localparam int HW = (HANDLE_BITS < CHILD_W) ? HANDLE_BITS : CHILD_W;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  // control state
  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  // request fields
  logic             accept;
  cmd_t             cmd;
  logic [KEY_W-1:0] req_key;
  logic [HW-1:0]    req_handle;

  // cell row
  logic [SLOTS-1:0] lt_v, eq_v, at_v, valid_v;
  logic [KEY_W-1:0] key_a    [SLOTS];
  logic [HW-1:0]    handle_a [SLOTS];
  op_t              op;

  // decision
  logic             full;
  logic             hit;
  logic [SLOTS-1:0] sel;
  logic [IW-1:0]    sel_idx;
  logic [HW-1:0]    sel_handle;
  status_t          status_next;
  logic             is_lookup;

  // result register
  status_t          res_status;
  logic [CHILD_W-1:0] res_found;
  logic [SLOT_W-1:0]  res_slot;
  logic [COUNT_W-1:0] res_count;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign cmd        = cmd_t'(s_tuser);
  assign req_key    = s_tdata[7:0];
  assign req_handle = HW'(s_tdata[39:8]);

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RST);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // full when count reaches capacity or the row size
  assign full = (MW'(count) >= MW'(capacity)) || (count == CW'(SLOTS));
  assign hit  = |(at_v & eq_v);

  // command decode
  always_comb begin
    op.key      = req_key;
    op.do_ins   = 1'b0;
    op.do_rem   = 1'b0;
    is_lookup   = 1'b0;
    status_next = ST_NOT_FOUND;
    sel         = '0;
    count_next  = count;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          op.do_ins   = accept;
          sel         = at_v;
          count_next  = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          status_next = ST_OK;
          op.do_rem   = accept;
          sel         = at_v & eq_v;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        is_lookup = 1'b1;
        if (hit) begin
          status_next = ST_OK;
          sel         = at_v & eq_v;
        end
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic          p_lt, p_valid, n_valid;
    logic [KEY_W-1:0] p_key, n_key;
    logic [HW-1:0] p_handle, n_handle;

    if (i == 0) begin : g_first
      assign p_lt     = 1'b1;
      assign p_valid  = 1'b1;
      assign p_key    = '0;
      assign p_handle = '0;
    end else begin : g_mid_lo
      assign p_lt     = lt_v[i-1];
      assign p_valid  = valid_v[i-1];
      assign p_key    = key_a[i-1];
      assign p_handle = handle_a[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign n_valid  = 1'b0;
      assign n_key    = '0;
      assign n_handle = '0;
    end else begin : g_mid_hi
      assign n_valid  = valid_v[i+1];
      assign n_key    = key_a[i+1];
      assign n_handle = handle_a[i+1];
    end

    skct_cell #(
      .HANDLE_W (HW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_handle  (req_handle),
      .prev_lt     (p_lt),
      .prev_valid  (p_valid),
      .prev_key    (p_key),
      .prev_handle (p_handle),
      .next_valid  (n_valid),
      .next_key    (n_key),
      .next_handle (n_handle),
      .lt          (lt_v[i]),
      .eq          (eq_v[i]),
      .at          (at_v[i]),
      .valid       (valid_v[i]),
      .key         (key_a[i]),
      .handle      (handle_a[i])
    );
  end

  // encode the selected slot and gather its handle
  always_comb begin
    sel_idx    = '0;
    sel_handle = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel[i]) begin
        sel_idx    = sel_idx | IW'(i);
        sel_handle = sel_handle | handle_a[i];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_found  <= (is_lookup && hit) ? CHILD_W'(sel_handle) : '0;
      res_slot   <= SLOT_W'(sel_idx);
      res_count  <= COUNT_W'(count_next);
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {7'd0, res_count, res_slot, res_found};

  // the number of valid bits set always equals the entry count
  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_v) == 32'(count))
    else $error("cell valid bits disagree with entry count");

  // at most one slot is ever selected
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(sel))
    else $error("more than one slot selected");

  // an accepted insert into a non-full table grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_INSERT && !full) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not advance entry count");

  // a full report never changes the table size
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_INSERT && full) |=> (count == $past(count)))
    else $error("entry count changed on full insert");

endmodule

// ----- sim/sorted_key_child_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_key_child_table_top_tb
// Self-checking bench for the sorted key / child table.
// ----------------------------------------------------------------------------
// Lookup, insert and remove requests go in on the slave stream. An in-bench
// model of the table predicts one reply per request, and the bench checks the
// master stream against it field by field. A short directed run on a 4-entry
// node covers the edge cases. Random phases follow, one capacity setting per
// phase (0 and 31 included), with stalls mostly on one side or on neither.
// ----------------------------------------------------------------------------
module sorted_key_child_table_top_tb;
  import skct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODE_SLOTS   = SLOTS_DEF;
  localparam logic [1:0]  CMD_SPARE    = 2'd3;   // unused code, behaves as lookup
  localparam int          PHASE_ITEMS  = 330;
  localparam int          STUCK_LIMIT  = 5000;

  // one predicted reply
  typedef struct packed {
    status_t              status;
    logic [CHILD_W-1:0]   found;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   count;
  } table_reply_t;

  // --------------------------------------------------------------------------
  // Node model and reply checker
  // --------------------------------------------------------------------------
  class table_scoreboard;
    logic [KEY_W-1:0]   stored_keys[NODE_SLOTS];
    logic [CHILD_W-1:0] node_handles[NODE_SLOTS];
    int unsigned        used;
    logic [CAP_W-1:0]   capacity;
    table_reply_t       predicted_replies[$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < NODE_SLOTS; i++) begin
        stored_keys[i]  = '0;
        node_handles[i] = '0;
      end
      used     = 0;
      capacity = CAP_W'(CAP_RST);
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    // first position below the count whose key is not less than key, else the count
    function int unsigned lower_slot(logic [KEY_W-1:0] key);
      int unsigned p;
      p = 0;
      while (p < used && stored_keys[p] < key) p++;
      return p;
    endfunction

    // apply one accepted request and queue its reply
    function void note_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                               logic [CHILD_W-1:0] handle);
      table_reply_t r;
      int unsigned  eff_cap;
      int unsigned  p;
      r.status = ST_NOT_FOUND;
      r.found  = '0;
      r.slot   = '0;
      eff_cap  = (capacity > NODE_SLOTS) ? NODE_SLOTS : capacity;
      if (cmd == CMD_INSERT) begin
        if (used >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          p = lower_slot(key);
          for (int i = used; i > p; i--) begin
            stored_keys[i]  = stored_keys[i-1];
            node_handles[i] = node_handles[i-1];
          end
          stored_keys[p]  = key;
          node_handles[p] = handle;
          used++;
          r.status = ST_OK;
          r.slot   = SLOT_W'(p);
        end
      end else if (cmd == CMD_REMOVE) begin
        p = lower_slot(key);
        if (p < used && stored_keys[p] == key) begin
          for (int i = p; i + 1 < used; i++) begin
            stored_keys[i]  = stored_keys[i+1];
            node_handles[i] = node_handles[i+1];
          end
          stored_keys[used-1]  = '0;
          node_handles[used-1] = '0;
          used--;
          r.status = ST_OK;
          r.slot   = SLOT_W'(p);
        end
      end else begin
        // lookup, spare code included: first match wins
        for (int i = 0; i < used; i++) begin
          if (stored_keys[i] == key) begin
            r.status = ST_OK;
            r.found  = node_handles[i];
            r.slot   = SLOT_W'(i);
            break;
          end
        end
      end
      r.count = COUNT_W'(used);
      predicted_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [CHILD_W-1:0] want,
                                logic [CHILD_W-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_reply(logic [1:0] status, logic [CHILD_W-1:0] found,
                              logic [SLOT_W-1:0] slot, logic [COUNT_W-1:0] count);
      table_reply_t want;
      if (predicted_replies.size() == 0) begin
        errors++;
        $error("reply with no request pending: status 0x%0h", status);
        return;
      end
      want = predicted_replies.pop_front();
      compare_field("status", CHILD_W'(want.status), CHILD_W'(status));
      compare_field("found_handle", want.found, found);
      compare_field("slot_index", CHILD_W'(want.slot), CHILD_W'(slot));
      compare_field("entry_count", CHILD_W'(want.count), CHILD_W'(count));
    endfunction

    function int unsigned pending();
      return predicted_replies.size();
    endfunction

    // key for stimulus: often one already stored, else narrow or full range
    function logic [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(99);
      if (used > 0 && r < 45) return stored_keys[$urandom_range(used - 1)];
      if (r < 70) return KEY_W'($urandom_range(15));
      return KEY_W'($urandom_range(255));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CAP_W-1:0]   cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [39:0]        s_tdata;   // key_byte[7:0], child_handle[39:8]
  logic [1:0]         s_tuser;   // command[1:0]
  logic               m_tvalid;
  logic               m_tready;
  logic [47:0]        m_tdata;   // found_handle[31:0], slot_index[35:32],
                                 // entry_count[40:36]
  logic [1:0]         m_tuser;   // status[1:0]

  table_scoreboard    sb;
  int unsigned        tx_gap_pct;
  int unsigned        rx_stall_pct;
  int unsigned        stuck_cycles;

  sorted_key_child_table_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // receiver backpressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= rx_stall_pct);
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_reply(m_tuser, m_tdata[31:0], m_tdata[35:32], m_tdata[40:36]);
  end

  // watchdog: no request or reply moving for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("sorted_key_child_table_top_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                              logic [CHILD_W-1:0] handle);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {handle, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(cmd, key, handle);
    @(negedge clk);
  endtask

  // hold off the sender until every reply is back
  task automatic drain_replies();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain_replies();
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic random_request();
    int unsigned r;
    logic [1:0]  cmd;
    r = $urandom_range(99);
    if (r < 40)      cmd = CMD_INSERT;
    else if (r < 70) cmd = CMD_REMOVE;
    else if (r < 95) cmd = CMD_LOOKUP;
    else             cmd = CMD_SPARE;
    send_request(cmd, sb.pick_key(), $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] phase_cap[6]  = '{5'd16, 5'd4, 5'd31, 5'd0, 5'd17, 5'd1};
  int unsigned      phase_mode[6] = '{0, 0, 1, 1, 2, 2};

  initial begin
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_LOOKUP;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 4-entry node, no stalls
    write_capacity(5'd4);
    send_request(CMD_LOOKUP, 8'h00, 32'h0);          // empty table
    send_request(CMD_REMOVE, 8'h80, 32'h0);          // remove from empty
    send_request(CMD_INSERT, 8'h80, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 8'h00, 32'h0000_0000);  // lowest key goes first
    send_request(CMD_INSERT, 8'hFF, 32'h5A5A_5A5A);  // highest key goes last
    send_request(CMD_INSERT, 8'h80, 32'h1234_5678);  // duplicate lands ahead
    send_request(CMD_INSERT, 8'h10, 32'hA5A5_A5A5);  // node full
    send_request(CMD_LOOKUP, 8'h80, 32'h0);          // finds newer duplicate
    send_request(CMD_SPARE,  8'hFF, 32'hFFFF_FFFF);  // spare code looks up
    send_request(CMD_LOOKUP, 8'h42, 32'h0);          // miss
    send_request(CMD_LOOKUP, 8'h00, 32'h0);          // hit with zero handle
    send_request(CMD_REMOVE, 8'h00, 32'h0);          // shift down from bottom
    send_request(CMD_REMOVE, 8'h80, 32'h0);
    send_request(CMD_LOOKUP, 8'h80, 32'h0);          // older duplicate remains
    send_request(CMD_REMOVE, 8'h80, 32'h0);
    send_request(CMD_REMOVE, 8'h80, 32'h0);          // now absent
    send_request(CMD_REMOVE, 8'hFF, 32'h0);          // back to empty
    send_request(CMD_INSERT, 8'h7F, 32'h8000_0001);
    send_request(CMD_LOOKUP, 8'h7F, 32'h0);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(phase_cap[ph]);
      unique case (phase_mode[ph])
        0: begin
          tx_gap_pct   = 13;
          rx_stall_pct = 45;
        end
        1: begin
          tx_gap_pct   = 45;
          rx_stall_pct = 13;
        end
        default: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        if ($urandom_range(149) == 0) drain_replies();
      end
    end

    // wrap up
    drain_replies();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_key_child_table_top_tb passed");
    end else begin
      $display("sorted_key_child_table_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/skct_pkg.sv
rtl/skct_cell.sv
rtl/sorted_key_child_table_top.sv
sim/sorted_key_child_table_top_tb.sv
